@@ rtl/core/mdtl_pkg.sv @@
// Shared types and constants for the modular-exponentiation letter decoder.
package mdtl_pkg;

  // Default residue width and register reset values
  localparam int RESIDUE_BITS_DEF = 12;
  localparam int EXPONENT_RESET   = 165;
  localparam int MODULUS_RESET    = 47 * 53;

  // Offset that turns a residue into a letter code
  localparam logic [7:0] LETTER_OFFSET = 8'd96;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_HOLD
  } state_t;

  // Control from the sequencer to the modular multiplier
  typedef struct packed {
    logic start;  // begin one multiply-reduce round
    logic wrap;   // modulus is zero: keep low bits instead of reducing
  } mm_ctrl_t;

endpackage

@@ rtl/core/mdtl_mulmod.sv @@
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module mdtl_mulmod
  import mdtl_pkg::*;
#(
  parameter int RESIDUE_BITS = RESIDUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mm_ctrl_t                ctrl,
  input  logic [RESIDUE_BITS-1:0] mcand,   // held for the whole round
  input  logic [RESIDUE_BITS-1:0] mplier,  // held for the whole round
  input  logic [RESIDUE_BITS-1:0] modulus, // held for the whole round
  output logic                    done,
  output logic [RESIDUE_BITS-1:0] result
);

  localparam int N     = RESIDUE_BITS;
  localparam int IDX_W = $clog2(RESIDUE_BITS);

  logic [N-1:0]     r_r, r_nxt;
  logic [IDX_W-1:0] idx_r;
  logic             busy_r;
  logic             done_r;
  logic             wrap_r;

  logic [N+1:0] addend, t, m1, m2;

  // One step: r = 2r + bit*mcand, then bring back below the modulus (or keep the low N bits in wrap mode)
  always_comb begin
    addend = mplier[idx_r] ? {2'b00, mcand} : '0;
    t      = {1'b0, r_r, 1'b0} + addend;
    m1     = {2'b00, modulus};
    m2     = {1'b0, modulus, 1'b0};
    priority if (wrap_r) begin
      r_nxt = t[N-1:0];
    end else if (t >= m2) begin
      r_nxt = N'(t - m2);
    end else if (t >= m1) begin
      r_nxt = N'(t - m1);
    end else begin
      r_nxt = t[N-1:0];
    end
  end

  // Step sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
      wrap_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        idx_r  <= IDX_W'(N - 1);
        wrap_r <= ctrl.wrap;
      end else if (busy_r) begin
        if (idx_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
    end
  end

  // Partial remainder
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
    end
  end

  assign done   = done_r;
  assign result = r_r;

endmodule

@@ rtl/core/modexp_decrypt_to_letter_unit.sv @@
// Each multiply-reduce round runs in the bit-serial modular multiplier, one round per
// exponent count; an exponent of zero runs no round. Items are accepted only in the idle
// state, so a new item starts only once the last result has gone to the output register;
// the output register lets the next item start while a result waits. Synchronous
// active-low reset clears control state and loads exponent 165, modulus 2491.
module modexp_decrypt_to_letter_unit
  import mdtl_pkg::*;
#(
  parameter int RESIDUE_BITS = RESIDUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [RESIDUE_BITS-1:0] cfg_wdata,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RESIDUE_BITS-1:0] in_cipher_value,
  input  logic                    in_last_item,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_plain_char,
  output logic [RESIDUE_BITS-1:0] out_residue,
  output logic                    out_last
);

  localparam int N = RESIDUE_BITS;

  logic [N-1:0] exponent_r, modulus_r;
  logic [N-1:0] held_value_r, acc_r, round_count_r;
  logic         last_r;
  state_t       state_r, state_nxt;

  logic         out_valid_r;
  logic [7:0]   out_char_r;
  logic [N-1:0] out_residue_r;
  logic         out_last_r;

  mm_ctrl_t     mm_ctrl;
  logic         mm_done;
  logic [N-1:0] mm_result;

  logic in_xfer, last_round, exp_zero, load_out;

  assign in_xfer    = in_valid && in_ready;
  assign exp_zero   = (exponent_r == '0);
  assign last_round = ((round_count_r + 1'b1) == exponent_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= N'(EXPONENT_RESET);
      modulus_r  <= N'(MODULUS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPONENT: exponent_r <= cfg_wdata;
        CFG_MODULUS:  modulus_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = exp_zero ? ST_HOLD : ST_ROUND;
      end
      ST_ROUND: begin
        if (mm_done && last_round) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    mm_ctrl.start = 1'b0;
    mm_ctrl.wrap  = (modulus_r == '0);
    load_out      = 1'b0;
    unique case (state_r)
      ST_IDLE:  begin
        in_ready      = 1'b1;
        mm_ctrl.start = in_valid && !exp_zero;
      end
      ST_ROUND: mm_ctrl.start = mm_done && !last_round;
      ST_HOLD:  load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item state: accumulator, round count, held cipher value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r         <= N'(1);
      round_count_r <= '0;
      held_value_r  <= '0;
      last_r        <= 1'b0;
    end else if (in_xfer) begin
      acc_r         <= N'(1);
      round_count_r <= '0;
      held_value_r  <= in_cipher_value;
      last_r        <= in_last_item;
    end else if (state_r == ST_ROUND && mm_done) begin
      acc_r         <= mm_result;
      round_count_r <= round_count_r + 1'b1;
    end
  end

  // Shared multiply-reduce unit
  mdtl_mulmod #(
    .RESIDUE_BITS (RESIDUE_BITS)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mm_ctrl),
    .mcand   (acc_r),
    .mplier  (held_value_r),
    .modulus (modulus_r),
    .done    (mm_done),
    .result  (mm_result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char_r    <= acc_r[7:0] + LETTER_OFFSET;
      out_residue_r <= acc_r;
      out_last_r    <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_plain_char = out_char_r;
  assign out_residue    = out_residue_r;
  assign out_last       = out_last_r;

`ifndef NO_ASSERTIONS
  // A round only starts on an accepted item or after a finished round
  a_start_src: assert property (@(posedge clk) disable iff (!rst_n)
    mm_ctrl.start |-> (state_r == ST_IDLE && in_valid) || (state_r == ST_ROUND && mm_done))
    else $error("multiplier started outside a round boundary");

  // Round count stays below the exponent while rounds run
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> round_count_r < exponent_r)
    else $error("round count overran exponent");

  // Multiplier completions only arrive while rounds are running
  a_done_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> state_r == ST_ROUND)
    else $error("multiplier done outside a round");

  // A finished result waits while the output register is still occupied
  a_hold_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && out_valid_r && !out_ready) |=> state_r == ST_HOLD)
    else $error("result dropped while output register full");
`endif

endmodule
